>>> src/pmsl_pkg.sv
// Shared types and constants for the position/speed PID loop core.
// Used by the top level and its checker; no dependencies.
package pmsl_pkg;

    typedef struct packed {
        logic signed [31:0] encoder_count;
        logic [31:0]        time_us;
        logic               enable;
    } in_item_t;

    typedef struct packed {
        logic signed [8:0]  drive;
        logic [7:0]         forward_level;
        logic [7:0]         reverse_level;
        logic signed [31:0] position_mdeg;
        logic signed [31:0] speed_mdeg_s;
        logic               stall_res;
        logic               updated;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MPOS,
        ST_DPOS,
        ST_MSPD,
        ST_DSPD,
        ST_PIDSEL,
        ST_MP,
        ST_MI,
        ST_MD,
        ST_FIN,
        ST_DONE
    } state_t;

    localparam logic [2:0] REG_GAIN_P    = 3'd0;
    localparam logic [2:0] REG_GAIN_I    = 3'd1;
    localparam logic [2:0] REG_GAIN_D    = 3'd2;
    localparam logic [2:0] REG_BOUND     = 3'd3;
    localparam logic [2:0] REG_CPT       = 3'd4;
    localparam logic [2:0] REG_MODE      = 3'd5;
    localparam logic [2:0] REG_POS_GOAL  = 3'd6;
    localparam logic [2:0] REG_SPD_GOAL  = 3'd7;

    localparam logic [1:0] MODE_POSITION = 2'd0;
    localparam logic [1:0] MODE_SPEED    = 2'd1;

    localparam logic signed [31:0] POS_SCALE   = 32'sd360000;
    localparam logic signed [31:0] SPD_SCALE   = 32'sd1000000;
    localparam logic [31:0]        DT_LIMIT    = 32'd100000;
    localparam logic signed [33:0] DRIVE_MAX   = 34'sd255;
    localparam logic signed [33:0] DRIVE_MIN   = -34'sd255;
    localparam logic signed [8:0]  STALL_DRIVE = 9'sd200;
    localparam logic signed [31:0] STALL_SPEED = 32'sd10000;
    localparam logic signed [31:0] STALL_ERR   = 32'sd5000;

    localparam logic [31:0] RST_GAIN_P = 32'd32768;
    localparam logic [31:0] RST_GAIN_I = 32'd3277;
    localparam logic [31:0] RST_GAIN_D = 32'd6554;
    localparam logic [30:0] RST_BOUND  = 31'd1000000;
    localparam logic [15:0] RST_CPT    = 16'd360;

endpackage

>>> src/pid_motor_position_speed_loop_core.sv
// Position/speed PID loop core: one control tick per input item, one result
// item per tick. Uses pmsl_pkg, pmsl_mul and pmsl_div.
//
// Each accepted item is processed on its own by a sequencer around one
// bit-serial 32x32 multiplier and one bit-serial divider, each working in
// 32 bit steps followed by a sign fix-up and a handoff. A disabled tick
// goes straight from idle to the done state. An enabled tick costs one
// multiply and one divide for position (count*360000/counts_per_turn),
// another multiply and divide for speed when the timestamp gap is in
// 1..99999 us, and, in position or speed mode, three multiplies for the
// PID terms. The next item is taken once the sequencer is back in idle;
// the finished result waits in the output register meanwhile.
// Configuration is always accepted (cfg_ready is high) and must be
// written only while the core is idle.
module pid_motor_position_speed_loop_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  pmsl_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output pmsl_pkg::out_item_t  m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data
);

    // configuration
    logic signed [31:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [30:0]        bound_reg;
    logic [15:0]        cpt_reg;
    logic [1:0]         mode_reg;
    logic signed [31:0] pos_goal_reg, spd_goal_reg;

    // loop state
    logic signed [31:0] position_reg, speed_reg, stamp_reg;
    logic signed [31:0] integral_reg, error_prev_reg;
    logic signed [8:0]  drive_reg;
    logic               stall_reg, enable_prev_reg;

    // per-tick working registers
    logic               en_reg;
    logic               dt_ok_reg;
    logic [16:0]        dt_reg;
    logic signed [31:0] prev_pos_reg;
    logic signed [31:0] err_reg, der_reg;
    logic signed [33:0] sum_reg;
    logic               updated_reg;

    pmsl_pkg::state_t   state_reg, state_next;
    pmsl_pkg::out_item_t m_data_reg;
    logic               m_valid_reg;

    // arithmetic unit handshake
    logic               mul_start, mul_done;
    logic signed [31:0] mul_a, mul_b;
    logic [63:0]        mul_prod;
    logic               div_start, div_done;
    logic signed [31:0] div_n;
    logic [16:0]        div_d;
    logic [31:0]        div_q;

    logic               accept, pid_mode, out_load;
    logic [31:0]        dt_calc;
    logic signed [31:0] err_calc, der_calc, term;
    logic signed [32:0] isum_calc, bnd_s;
    logic signed [31:0] isum_clamped;
    logic signed [33:0] sum_shift;
    logic signed [8:0]  drive_calc, drive_neg;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == pmsl_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign pid_mode  = (mode_reg == pmsl_pkg::MODE_POSITION)
                    || (mode_reg == pmsl_pkg::MODE_SPEED);
    assign out_load  = (state_reg == pmsl_pkg::ST_DONE) && (!m_valid_reg || m_ready);

    assign dt_calc  = s_data.time_us - stamp_reg;
    assign err_calc = (mode_reg == pmsl_pkg::MODE_POSITION) ? (pos_goal_reg - position_reg)
                                                           : (spd_goal_reg - speed_reg);
    assign der_calc = err_calc - error_prev_reg;
    assign bnd_s    = $signed({2'b00, bound_reg});
    assign isum_calc = 33'(integral_reg) + 33'(err_calc);
    assign isum_clamped = (isum_calc > bnd_s)  ? 32'(bnd_s)
                        : (isum_calc < -bnd_s) ? 32'(-bnd_s)
                        : 32'(isum_calc);
    // Q-format term: keep the low 32 bits of the product shifted down
    assign term      = $signed(mul_prod[FRAC_BITS +: 32]);
    assign sum_shift = sum_reg >>> 8;
    assign drive_calc = (sum_shift > pmsl_pkg::DRIVE_MAX) ? 9'sd255
                      : (sum_shift < pmsl_pkg::DRIVE_MIN) ? -9'sd255
                      : 9'(sum_shift);
    assign drive_neg = 9'(-drive_reg);

    pmsl_mul u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start), .op_a(mul_a),
        .op_b(mul_b), .done(mul_done), .product(mul_prod)
    );

    pmsl_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(div_n),
        .divisor(div_d), .done(div_done), .quotient(div_q)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pmsl_pkg::ST_IDLE: begin
                if (accept) state_next = s_data.enable ? pmsl_pkg::ST_MPOS
                                                       : pmsl_pkg::ST_DONE;
            end
            pmsl_pkg::ST_MPOS: if (mul_done) state_next = pmsl_pkg::ST_DPOS;
            pmsl_pkg::ST_DPOS: begin
                if (div_done) state_next = dt_ok_reg ? pmsl_pkg::ST_MSPD
                                                     : pmsl_pkg::ST_PIDSEL;
            end
            pmsl_pkg::ST_MSPD: if (mul_done) state_next = pmsl_pkg::ST_DSPD;
            pmsl_pkg::ST_DSPD: if (div_done) state_next = pmsl_pkg::ST_PIDSEL;
            pmsl_pkg::ST_PIDSEL: state_next = pid_mode ? pmsl_pkg::ST_MP : pmsl_pkg::ST_DONE;
            pmsl_pkg::ST_MP: if (mul_done) state_next = pmsl_pkg::ST_MI;
            pmsl_pkg::ST_MI: if (mul_done) state_next = pmsl_pkg::ST_MD;
            pmsl_pkg::ST_MD: if (mul_done) state_next = pmsl_pkg::ST_FIN;
            pmsl_pkg::ST_FIN: state_next = pmsl_pkg::ST_DONE;
            pmsl_pkg::ST_DONE: if (out_load) state_next = pmsl_pkg::ST_IDLE;
            default: state_next = pmsl_pkg::ST_IDLE;
        endcase
    end

    // unit starts and operand selection
    always_comb begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_n     = '0;
        div_d     = '0;
        case (state_reg)
            pmsl_pkg::ST_IDLE: begin
                mul_start = accept && s_data.enable;
                mul_a     = s_data.encoder_count;
                mul_b     = pmsl_pkg::POS_SCALE;
            end
            pmsl_pkg::ST_MPOS: begin
                div_start = mul_done;
                div_n     = $signed(mul_prod[31:0]);
                div_d     = (cpt_reg == 16'd0) ? 17'd1 : {1'b0, cpt_reg};
            end
            pmsl_pkg::ST_DPOS: begin
                mul_start = div_done && dt_ok_reg;
                mul_a     = $signed(div_q) - prev_pos_reg;
                mul_b     = pmsl_pkg::SPD_SCALE;
            end
            pmsl_pkg::ST_MSPD: begin
                div_start = mul_done;
                div_n     = $signed(mul_prod[31:0]);
                div_d     = dt_reg;
            end
            pmsl_pkg::ST_PIDSEL: begin
                mul_start = pid_mode;
                mul_a     = gain_p_reg;
                mul_b     = err_calc;
            end
            pmsl_pkg::ST_MP: begin
                mul_start = mul_done;
                mul_a     = gain_i_reg;
                mul_b     = integral_reg;
            end
            pmsl_pkg::ST_MI: begin
                mul_start = mul_done;
                mul_a     = gain_d_reg;
                mul_b     = der_reg;
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
    end

    // sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= pmsl_pkg::ST_IDLE;
        else          state_reg <= state_next;
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg   <= pmsl_pkg::RST_GAIN_P;
            gain_i_reg   <= pmsl_pkg::RST_GAIN_I;
            gain_d_reg   <= pmsl_pkg::RST_GAIN_D;
            bound_reg    <= pmsl_pkg::RST_BOUND;
            cpt_reg      <= pmsl_pkg::RST_CPT;
            mode_reg     <= pmsl_pkg::MODE_POSITION;
            pos_goal_reg <= '0;
            spd_goal_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                pmsl_pkg::REG_GAIN_P:   gain_p_reg   <= cfg_data;
                pmsl_pkg::REG_GAIN_I:   gain_i_reg   <= cfg_data;
                pmsl_pkg::REG_GAIN_D:   gain_d_reg   <= cfg_data;
                pmsl_pkg::REG_BOUND:    bound_reg    <= cfg_data[30:0];
                pmsl_pkg::REG_CPT:      cpt_reg      <= cfg_data[15:0];
                pmsl_pkg::REG_MODE:     mode_reg     <= cfg_data[1:0];
                pmsl_pkg::REG_POS_GOAL: pos_goal_reg <= cfg_data;
                pmsl_pkg::REG_SPD_GOAL: spd_goal_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // loop state and working registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg    <= '0;
            speed_reg       <= '0;
            stamp_reg       <= '0;
            integral_reg    <= '0;
            error_prev_reg  <= '0;
            drive_reg       <= '0;
            stall_reg       <= 1'b0;
            enable_prev_reg <= 1'b0;
            updated_reg     <= 1'b0;
            en_reg          <= 1'b0;
            dt_ok_reg       <= 1'b0;
        end else begin
            case (state_reg)
                pmsl_pkg::ST_IDLE: begin
                    if (accept) begin
                        // rising enable: drop integral and last error
                        if (s_data.enable && !enable_prev_reg) begin
                            integral_reg   <= '0;
                            error_prev_reg <= '0;
                        end
                        enable_prev_reg <= s_data.enable;
                        en_reg          <= s_data.enable;
                        updated_reg     <= 1'b0;
                        if (s_data.enable) begin
                            stamp_reg    <= s_data.time_us;
                            prev_pos_reg <= position_reg;
                            dt_reg       <= dt_calc[16:0];
                            dt_ok_reg    <= (dt_calc != 32'd0) && (dt_calc < pmsl_pkg::DT_LIMIT);
                        end
                    end
                end
                pmsl_pkg::ST_DPOS: if (div_done) position_reg <= div_q;
                pmsl_pkg::ST_DSPD: if (div_done) speed_reg <= div_q;
                pmsl_pkg::ST_PIDSEL: begin
                    if (pid_mode) begin
                        err_reg      <= err_calc;
                        der_reg      <= der_calc;
                        integral_reg <= isum_clamped;
                    end
                end
                pmsl_pkg::ST_MP: if (mul_done) sum_reg <= 34'(term);
                pmsl_pkg::ST_MI: if (mul_done) sum_reg <= sum_reg + 34'(term);
                pmsl_pkg::ST_MD: if (mul_done) sum_reg <= sum_reg + 34'(term);
                pmsl_pkg::ST_FIN: begin
                    drive_reg      <= drive_calc;
                    error_prev_reg <= err_reg;
                    updated_reg    <= 1'b1;
                    if (mode_reg == pmsl_pkg::MODE_POSITION) begin
                        stall_reg <= (drive_calc > pmsl_pkg::STALL_DRIVE
                                      || drive_calc < -pmsl_pkg::STALL_DRIVE)
                                  && (speed_reg > -pmsl_pkg::STALL_SPEED
                                      && speed_reg < pmsl_pkg::STALL_SPEED)
                                  && (err_reg > pmsl_pkg::STALL_ERR
                                      || err_reg < -pmsl_pkg::STALL_ERR);
                    end
                end
                default: ;
            endcase
        end
    end

    // result register: hold until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.drive         <= drive_reg;
            m_data_reg.forward_level <= (en_reg && drive_reg > 9'sd0) ? drive_reg[7:0] : 8'd0;
            m_data_reg.reverse_level <= (en_reg && drive_reg < 9'sd0) ? drive_neg[7:0] : 8'd0;
            m_data_reg.position_mdeg <= position_reg;
            m_data_reg.speed_mdeg_s  <= speed_reg;
            m_data_reg.stall_res     <= stall_reg;
            m_data_reg.updated       <= updated_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> src/pmsl_mul.sv
// Bit-serial signed 32x32 multiplier, one multiplier bit per cycle.
// Depends on nothing; used by the top level for all products.
module pmsl_mul (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [31:0] op_a,
    input  logic signed [31:0] op_b,
    output logic               done,
    output logic [63:0]        product
);

    logic [31:0] mcand_reg;
    logic [64:0] acc_reg;
    logic [64:0] acc_next;
    logic [32:0] upper_sum;
    logic        neg_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        fin_reg;
    logic        done_reg;
    logic [63:0] product_reg;

    assign upper_sum = acc_reg[64:32] + (acc_reg[0] ? {1'b0, mcand_reg} : 33'd0);
    assign acc_next  = {1'b0, upper_sum, acc_reg[31:1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            fin_reg  <= 1'b0;
            if (start) begin
                mcand_reg <= op_a[31] ? 32'(-op_a) : op_a;
                acc_reg   <= {33'd0, (op_b[31] ? 32'(-op_b) : op_b)};
                neg_reg   <= op_a[31] ^ op_b[31];
                cnt_reg   <= '0;
                busy_reg  <= 1'b1;
            end else if (busy_reg) begin
                acc_reg <= acc_next;
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            if (fin_reg) begin
                product_reg <= neg_reg ? 64'(-acc_reg[63:0]) : acc_reg[63:0];
                done_reg    <= 1'b1;
            end
        end
    end

    assign done    = done_reg;
    assign product = product_reg;

endmodule

>>> src/pmsl_div.sv
// Bit-serial restoring divider: signed 32-bit dividend by a positive 17-bit
// divisor, quotient truncated toward zero. No dependencies.
module pmsl_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [31:0] dividend,
    input  logic [16:0]        divisor,
    output logic               done,
    output logic [31:0]        quotient
);

    logic [17:0] rem_reg;
    logic [31:0] q_reg;
    logic [16:0] dvs_reg;
    logic        neg_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        fin_reg;
    logic        done_reg;
    logic [31:0] quot_reg;
    logic [17:0] trial;
    logic        fits;

    assign trial = {rem_reg[16:0], q_reg[31]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            fin_reg  <= 1'b0;
            if (start) begin
                q_reg    <= dividend[31] ? 32'(-dividend) : dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
                neg_reg  <= dividend[31];
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= fits ? 18'(trial - {1'b0, dvs_reg}) : trial;
                q_reg   <= {q_reg[30:0], fits};
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            if (fin_reg) begin
                quot_reg <= neg_reg ? 32'(-q_reg) : q_reg;
                done_reg <= 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

>>> src/pmsl_checker.sv
// Port-level checker for the PID loop core, bound to the top level.
// Uses pmsl_pkg for the result item type.
module pmsl_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input pmsl_pkg::out_item_t m_data
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item dropped or changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_fwd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.forward_level != 8'd0 |->
            m_data.reverse_level == 8'd0 && m_data.drive == $signed({1'b0, m_data.forward_level}))
        else $error("forward level does not match drive");

    a_rev: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.reverse_level != 8'd0 |->
            m_data.drive == -$signed({1'b0, m_data.reverse_level}))
        else $error("reverse level does not match drive");

endmodule

bind pid_motor_position_speed_loop_core pmsl_checker u_pmsl_checker (
    .aclk(aclk), .aresetn(aresetn), .m_valid(m_valid), .m_ready(m_ready),
    .m_data(m_data)
);
